/* src/bsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// shared constants, types and helpers of the byte stream reassembler
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 32;
  localparam int BYTE_W   = 8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // request to the byte store
  typedef struct packed {
    logic  we;
    slot_t waddr;
    byte_t wdata;
    logic  re;
    slot_t raddr;
  } ram_req_t;

  // result status from the controller
  typedef struct packed {
    logic valid;
    logic byte_valid;
    logic run_last;
    cnt_t pending;
    logic ended;
  } res_ctl_t;

  // ring position base + off, off below CAPACITY
  function automatic slot_t ring_add(slot_t base, logic [SLOT_W:0] off);
    logic [SLOT_W:0] s;
    s = {1'b0, base} + off;
    if (s >= (SLOT_W + 1)'(CAPACITY)) begin
      s = s - (SLOT_W + 1)'(CAPACITY);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

/* src/bsr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_if
// valid/ready channels for segment words and result words
// ----------------------------------------------------------------------------
interface bsr_seg_if;
  logic           valid;
  logic           ready;
  bsr_pkg::idx_t  segment_start;
  bsr_pkg::idx_t  byte_index;
  bsr_pkg::byte_t data_byte;
  logic           has_byte;
  logic           eof;

  modport source (output valid, segment_start, byte_index, data_byte, has_byte, eof,
                  input ready);
  modport sink (input valid, segment_start, byte_index, data_byte, has_byte, eof,
                output ready);
endinterface

interface bsr_res_if;
  logic           valid;
  logic           ready;
  logic           byte_valid;
  bsr_pkg::byte_t out_byte;
  logic           run_last;
  bsr_pkg::cnt_t  pending_count;
  logic           stream_ended;

  modport source (output valid, byte_valid, out_byte, run_last, pending_count,
                  stream_ended, input ready);
  modport sink (input valid, byte_valid, out_byte, run_last, pending_count,
                stream_ended, output ready);
endinterface

/* src/bsr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bsr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_ctrl
// window state, valid marks and the store/drain sequencer
// ----------------------------------------------------------------------------
module bsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  bsr_pkg::idx_t     segment_start_i,
  input  bsr_pkg::idx_t     byte_index_i,
  input  bsr_pkg::byte_t    data_byte_i,
  input  logic              has_byte_i,
  input  logic              eof_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output bsr_pkg::ram_req_t ram_req_o,
  output bsr_pkg::res_ctl_t res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [bsr_pkg::CAPACITY-1:0] valid_q, valid_d;
  bsr_pkg::idx_t                next_q, next_d;
  bsr_pkg::slot_t               head_q, head_d;
  bsr_pkg::cnt_t                pend_q, pend_d;
  logic                         eof_seen_q, eof_seen_d;
  logic                         ended_q, ended_d;
  logic                         bvalid_q, bvalid_d;
  logic                         last_q, last_d;

  bsr_pkg::idx_t  off;
  logic           in_win;
  bsr_pkg::slot_t slot;
  bsr_pkg::slot_t head_nxt;
  logic           in_acc;
  logic           eof_ok;
  logic           store;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign off      = byte_index_i - next_q;
  assign in_win   = off < bsr_pkg::IDX_W'(bsr_pkg::CAPACITY);
  assign slot     = bsr_pkg::ring_add(head_q, off[bsr_pkg::SLOT_W:0]);
  assign head_nxt = bsr_pkg::ring_add(head_q, (bsr_pkg::SLOT_W + 1)'(1));
  // eof window compare is done without wrap
  assign eof_ok   = eof_i && ({1'b0, segment_start_i} <
                    ({1'b0, next_q} + (bsr_pkg::IDX_W + 1)'(bsr_pkg::CAPACITY)));
  assign store    = in_acc && has_byte_i && in_win && !valid_q[slot];

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    next_d     = next_q;
    head_d     = head_q;
    pend_d     = pend_q;
    eof_seen_d = eof_seen_q;
    bvalid_d   = bvalid_q;
    last_d     = last_q;
    ram_req_o  = '{we: store, waddr: slot, wdata: data_byte_i, re: 1'b0, raddr: head_q};
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (eof_ok) begin
            eof_seen_d = 1'b1;
          end
          if (store) begin
            valid_d[slot] = 1'b1;
            pend_d        = pend_q + bsr_pkg::CNT_W'(1);
          end
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (valid_q[head_q]) begin
          ram_req_o.re    = 1'b1;
          valid_d[head_q] = 1'b0;
          head_d          = head_nxt;
          next_d          = next_q + bsr_pkg::IDX_W'(1);
          pend_d          = pend_q - bsr_pkg::CNT_W'(1);
          bvalid_d        = 1'b1;
          last_d          = !valid_q[head_nxt];
        end else begin
          // nothing to release: one status-only word
          bvalid_d = 1'b0;
          last_d   = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = last_q ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ended_d = ended_q | (eof_seen_d & (pend_d == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      next_q     <= '0;
      head_q     <= '0;
      pend_q     <= '0;
      eof_seen_q <= 1'b0;
      ended_q    <= 1'b0;
      bvalid_q   <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      next_q     <= next_d;
      head_q     <= head_d;
      pend_q     <= pend_d;
      eof_seen_q <= eof_seen_d;
      ended_q    <= ended_d;
      bvalid_q   <= bvalid_d;
      last_q     <= last_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign res_o      = '{valid: (state_q == ST_EMIT), byte_valid: bvalid_q,
                        run_last: last_q, pending: pend_q, ended: ended_q};

endmodule

/* src/byte_stream_reassembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_reassembler
// out-of-order byte reassembly over a ring window with in-order release
// ----------------------------------------------------------------------------
// Each input word carries at most one stream byte with its absolute index.
// Bytes within CAPACITY of the next expected index are parked in a ring
// byte store (a registered-read ram) with a valid mark per slot; a byte
// already held is ignored, bytes outside the window are dropped. After every
// input word the contiguous run at the head is released in order, one result
// word per byte, the last one flagged run_last; when nothing is released a
// single status-only word (byte_valid low, run_last high) is sent instead.
// Sequence: one word is taken per pass. The accept cycle writes the store,
// then each result takes a store read state and an output state that holds
// until the sink is ready. The separate read state is due to the registered
// read of the store; no new word is taken before the last result is accepted.
// There is no clearing pass: valid marks reset at once in flip-flops.
module byte_stream_reassembler (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsr_seg_if.sink   seg_i,
  bsr_res_if.source res_o
);

  bsr_pkg::ram_req_t ram_req;
  bsr_pkg::res_ctl_t res_ctl;
  bsr_pkg::byte_t    rdata;

  // sequencer, window state and valid marks
  bsr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (seg_i.valid),
    .segment_start_i (seg_i.segment_start),
    .byte_index_i    (seg_i.byte_index),
    .data_byte_i     (seg_i.data_byte),
    .has_byte_i      (seg_i.has_byte),
    .eof_i           (seg_i.eof),
    .in_ready_o      (seg_i.ready),
    .out_ready_i     (res_o.ready),
    .ram_req_o       (ram_req),
    .res_o           (res_ctl)
  );

  // byte store, written on accept, read one slot per released byte
  bsr_ram #(
    .WIDTH (bsr_pkg::BYTE_W),
    .DEPTH (bsr_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  // read data holds while the result word waits; status words carry zero
  assign res_o.valid         = res_ctl.valid;
  assign res_o.byte_valid    = res_ctl.byte_valid;
  assign res_o.out_byte      = res_ctl.byte_valid ? rdata : '0;
  assign res_o.run_last      = res_ctl.run_last;
  assign res_o.pending_count = res_ctl.pending;
  assign res_o.stream_ended  = res_ctl.ended;

endmodule

/* src/bsr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_checker
// port-level checks of the reassembler, bound to the top level
// ----------------------------------------------------------------------------
module bsr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic          byte_valid_i,
  input logic          run_last_i,
  input bsr_pkg::cnt_t pending_count_i,
  input logic          stream_ended_i
);

  logic ended_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && stream_ended_i) begin
      ended_seen_q <= 1'b1;
    end
  end

  // no result in the cycle right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result word right after accept");

  // input is never taken while a result is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready during result");

  // status-only word always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> run_last_i)
    else $error("status word without run_last");

  // end of stream is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ended_seen_q |-> stream_ended_i)
    else $error("stream_ended dropped");

  // pending never exceeds the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_count_i <= bsr_pkg::CNT_W'(bsr_pkg::CAPACITY))
    else $error("pending count beyond capacity");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (seg_i.valid),
  .in_ready_i      (seg_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .byte_valid_i    (res_o.byte_valid),
  .run_last_i      (res_o.run_last),
  .pending_count_i (res_o.pending_count),
  .stream_ended_i  (res_o.stream_ended)
);
